FILE: rtl/lkv_pkg.sv
// Package for the LRU key/value cache: sizes, control codes and the structs
// that run between the sequencer and the row of entry cells.
// No dependencies.
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 32;
  localparam int CAP_W      = 5;
  localparam int AGE_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register index of capacity
  localparam logic REG_CAPACITY = 1'b0;

  // item command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_VICTIM,
    UPD_FILL
  } upd_kind_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  match_en;
    logic                  upd_en;
    upd_kind_e             kind;
    logic                  is_set;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [AGE_W-1:0]      touch_age;
    logic [AGE_W-1:0]      last_age;
  } cell_ctrl_t;

  // ripple from cell to cell
  typedef struct packed {
    logic                  free_seen;
    logic                  hit;
    logic [AGE_W-1:0]      age;
    logic [VALUE_BITS-1:0] value;
  } chain_t;

endpackage

`default_nettype wire

FILE: rtl/lkv_cell.sv
// One entry of the LRU cache: key, value, valid mark, recency rank.
// Depends on lkv_pkg.
`default_nettype none

module lkv_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lkv_pkg::cell_ctrl_t ctrl_i,
  input  wire lkv_pkg::chain_t    chain_i,
  output lkv_pkg::chain_t         chain_o
);
  import lkv_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  valid_q, valid_d;
  logic [AGE_W-1:0]      age_q, age_d;
  logic                  match_q;
  logic                  sel;
  logic                  wr_key, wr_value;

  // pass the lookup results down the row
  always_comb begin
    chain_o.free_seen = chain_i.free_seen | ~valid_q;
    chain_o.hit       = chain_i.hit | match_q;
    chain_o.age       = chain_i.age | (match_q ? age_q : '0);
    chain_o.value     = chain_i.value | (match_q ? value_q : '0);
  end

  always_comb begin
    case (ctrl_i.kind)
      UPD_HIT:    sel = match_q;
      UPD_VICTIM: sel = valid_q && (age_q == ctrl_i.last_age);
      UPD_FILL:   sel = ~valid_q && ~chain_i.free_seen;
      default:    sel = 1'b0;
    endcase
  end

  always_comb begin
    valid_d  = valid_q;
    age_d    = age_q;
    wr_key   = 1'b0;
    wr_value = 1'b0;
    if (ctrl_i.upd_en && ctrl_i.kind != UPD_NONE) begin
      if (sel) begin
        age_d    = '0;
        valid_d  = 1'b1;
        wr_key   = (ctrl_i.kind != UPD_HIT);
        wr_value = (ctrl_i.kind != UPD_HIT) || ctrl_i.is_set;
      end else if (valid_q) begin
        if (ctrl_i.kind == UPD_FILL || age_q < ctrl_i.touch_age) begin
          age_d = age_q + AGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      if (ctrl_i.match_en) begin
        match_q <= valid_q && (key_q == ctrl_i.key);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_q <= ctrl_i.key;
    end
    if (wr_value) begin
      value_q <= ctrl_i.value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key/value cache: APB register, item sequencer,
// row of entry cells and result register. Depends on lkv_pkg, lkv_cell.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one item: cmd_i
//    (get or set), key_i, write_value_i. Output channel (out_valid_o /
//    out_stall_i) returns one item per input: hit_o and read_value_o.
//  - Every item passes three steps: accept, match (all cells compare their
//    key against the item key and register a match bit), update (lookup
//    results ripple down the cell row, every cell updates its age, the
//    chosen cell takes key/value). A new item is accepted only in the idle
//    state, once the previous item has left its update step.
//  - out_valid_o comes from the result register, loaded as the update step ends.
//  - A result waits in the output register while out_stall_i is high; the
//    next item is still accepted and runs up to its update cycle, where it
//    waits until the output register is free.
//  - Capacity sits at byte address 0 of the APB port (reset 16). A value of
//    zero acts as one, values above 16 as 16. Write only while idle.
//  - Reset empties the cache (all valid marks and ages cleared, fill count
//    zero) and drops any item in flight; no clearing pass is needed.
`default_nettype none

module lru_key_value_cache_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             cmd_i,
  input  wire logic [lkv_pkg::KEY_BITS-1:0]     key_i,
  input  wire logic [lkv_pkg::VALUE_BITS-1:0]   write_value_i,
  // result output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  hit_o,
  output logic [lkv_pkg::VALUE_BITS-1:0]        read_value_o,
  // APB register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lkv_pkg::APB_AW-1:0]       paddr,
  input  wire logic [lkv_pkg::APB_DW-1:0]       pwdata,
  output logic [lkv_pkg::APB_DW-1:0]            prdata,
  output logic                                  pready
);
  import lkv_pkg::*;

  state_e                state_q, state_d;
  logic [CAP_W-1:0]      capacity_q;
  logic [CNT_W-1:0]      fill_q;
  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wval_q;
  logic                  out_valid_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] rdata_q;

  logic       accept;
  logic       out_free;
  logic       match_en, upd_en;
  cell_ctrl_t ctrl;
  chain_t     chain [ENTRIES+1];
  chain_t     res;
  upd_kind_e  kind;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic       reg_sel;

  // ---------------- APB register ----------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_CAPACITY);
  assign prdata  = reg_sel ? APB_DW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // clamp capacity into 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(capacity_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // ---------------- sequencer ----------------
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign accept   = in_valid_i && ~in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MATCH;
      ST_MATCH:  state_d = ST_UPDATE;
      ST_UPDATE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    match_en   = 1'b0;
    upd_en     = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_MATCH:  match_en   = 1'b1;
      ST_UPDATE: upd_en     = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      wval_q <= write_value_i;
    end
  end

  // ---------------- cell row ----------------
  assign chain[0] = '0;
  assign res      = chain[ENTRIES];

  // pick the update: touch on hit, none on a get miss, fill while below capacity, else evict
  always_comb begin
    if (res.hit) begin
      kind = UPD_HIT;
    end else if (cmd_q == CMD_GET) begin
      kind = UPD_NONE;
    end else if (CMP_W'(fill_q) < eff_cap) begin
      kind = UPD_FILL;
    end else begin
      kind = UPD_VICTIM;
    end
  end

  always_comb begin
    ctrl.match_en  = match_en;
    ctrl.upd_en    = upd_en;
    ctrl.kind      = kind;
    ctrl.is_set    = (cmd_q == CMD_SET);
    ctrl.key       = key_q;
    ctrl.value     = wval_q;
    ctrl.last_age  = AGE_W'(fill_q - CNT_W'(1));
    ctrl.touch_age = (kind == UPD_VICTIM) ? ctrl.last_age : res.age;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (upd_en && kind == UPD_FILL) begin
      fill_q <= fill_q + CNT_W'(1);
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_en) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      hit_q   <= res.hit;
      rdata_q <= (res.hit && cmd_q == CMD_GET) ? res.value : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;

endmodule

`default_nettype wire

FILE: bench/lru_key_value_cache_unit_tb.sv
// Self-checking bench for lru_key_value_cache_unit: directed and random get/set
// items against an in-bench LRU shadow, with random idling on both channels.
// Depends on lkv_pkg and the RTL of the cache.
`default_nettype none

module lru_key_value_cache_unit_tb;
  import lkv_pkg::*;

  // cycles with no item moving on either channel before the run is called hung
  localparam int HANG_LIMIT = 2000;
  // quiet cycles after the last result before touching the register
  localparam int SETTLE = 6;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 90;
  localparam int POOL_MAX = 20;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
  localparam logic [VALUE_BITS-1:0] VAL_ONES = '1;

  // Shadow copy of the cache. Every accepted item runs through it in order
  // and leaves one owed lookup result behind.
  class lru_shadow;
    typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] value;
    } lookup_t;

    logic [KEY_BITS-1:0]   keys[ENTRIES];
    logic [VALUE_BITS-1:0] vals[ENTRIES];
    bit                    live[ENTRIES];
    logic [AGE_W-1:0]      age[ENTRIES];
    int                    fill;
    logic [CAP_W-1:0]      capacity;
    lookup_t               owed[$];
    int                    mismatches;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        age[i]  = '0;
      end
      fill       = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    // zero acts as one, anything above the entry count saturates
    function int eff_capacity();
      int c;
      c = int'(capacity);
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    function void write_reg(int idx, logic [APB_DW-1:0] data);
      if (idx == int'(REG_CAPACITY)) capacity = data[CAP_W-1:0];
    endfunction

    function int find_key(logic [KEY_BITS-1:0] key);
      foreach (live[i])
        if (live[i] && keys[i] == key) return i;
      return -1;
    endfunction

    // make an entry the youngest; only entries younger than it get older
    function void promote(int idx);
      logic [AGE_W-1:0] a;
      a = age[idx];
      foreach (live[i])
        if (live[i] && i != idx && age[i] < a) age[i] = age[i] + 1'b1;
      age[idx] = '0;
    endfunction

    function void note_op(logic cmd, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] wval);
      int slot;
      int victim;
      lookup_t res;
      slot      = find_key(key);
      res.hit   = (slot >= 0);
      res.value = '0;
      if (cmd == CMD_GET) begin
        if (slot >= 0) begin
          res.value = vals[slot];
          promote(slot);
        end
      end else if (slot >= 0) begin
        vals[slot] = wval;
        promote(slot);
      end else if (fill < eff_capacity()) begin
        // fill < capacity <= ENTRIES, so a free slot exists
        slot = 0;
        while (live[slot]) slot++;
        foreach (live[i])
          if (live[i]) age[i] = age[i] + 1'b1;
        live[slot] = 1'b1;
        keys[slot] = key;
        vals[slot] = wval;
        age[slot]  = '0;
        fill++;
      end else begin
        // oldest entry, lowest index on a tie
        victim = -1;
        foreach (live[i])
          if (live[i] && (victim < 0 || age[i] > age[victim])) victim = i;
        keys[victim] = key;
        vals[victim] = wval;
        promote(victim);
      end
      owed.push_back(res);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic hit, logic [VALUE_BITS-1:0] value);
      lookup_t want;
      if (owed.size() == 0) begin
        report($sformatf("result hit=%0b value=%h with no item outstanding", hit, value));
      end else begin
        want = owed.pop_front();
        if (hit !== want.hit)
          report($sformatf("hit %0b, want %0b", hit, want.hit));
        if (value !== want.value)
          report($sformatf("read_value %h, want %h", value, want.value));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  cmd_i = CMD_GET;
  logic [KEY_BITS-1:0]   key_i = '0;
  logic [VALUE_BITS-1:0] write_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [VALUE_BITS-1:0] read_value_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  lru_shadow shadow = new();

  // idling odds in percent, changed per phase
  int src_idle_pct = 13;
  int sink_stall_pct = 59;
  int idle_cycles = 0;

  logic [KEY_BITS-1:0] key_pool[POOL_MAX];
  int pool_len = 4;

  lru_key_value_cache_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall decided fresh every cycle.
  always @(negedge clk) out_stall_i <= ($urandom_range(99) < sink_stall_pct);

  // Both channels sampled at the rising edge. The input is noted first so a
  // result can never race ahead of its own item in the shadow.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) shadow.note_op(cmd_i, key_i, write_value_i);
      if (out_valid_o && !out_stall_i) shadow.check_result(hit_o, read_value_o);
    end
  end

  // Hang detector: cycles in which no item moves either way.
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == HANG_LIMIT) begin
      $display("[lru_key_value_cache_unit] ERROR");
      $finish;
    end
  end

  // One item on the input channel; entered and left at a falling edge.
  // Valid stays high between back-to-back items.
  task automatic send_item(logic cmd, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] wval);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    key_i         <= key;
    write_value_i <= wval;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  // Wait out every owed result, then a few quiet cycles.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic wr_reg(int idx, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Keys mostly from a pool a bit larger than the capacity, so hits, updates
  // and evictions all happen; the rest are fresh keys or the extremes.
  task automatic run_random(int count);
    int r;
    logic cmd;
    logic [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0] wval;
    repeat (count) begin
      cmd = ($urandom_range(1) == 0) ? CMD_GET : CMD_SET;
      r = $urandom_range(99);
      if (r < 70) key = key_pool[$urandom_range(pool_len - 1)];
      else if (r < 73) key = '0;
      else if (r < 76) key = KEY_ONES;
      else key = {$urandom(), $urandom()};
      r = $urandom_range(99);
      if (r < 5) wval = '0;
      else if (r < 10) wval = VAL_ONES;
      else wval = $urandom();
      send_item(cmd, key, wval);
    end
  endtask

  initial begin
    // capacities per phase: saturation, zero-as-one, and a drop below the
    // fill level after a full cache
    int phase_caps[PHASES];
    logic [KEY_BITS-1:0] k_a;
    logic [KEY_BITS-1:0] k_b;
    logic [KEY_BITS-1:0] k_c;
    phase_caps = '{16, 1, 0, 31, 4, 16, 3};
    k_a = {$urandom(), $urandom()};
    k_b = {$urandom(), $urandom()} ^ 64'h1;
    k_c = ~k_a;

    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // --- directed ---
    wr_reg(int'(REG_CAPACITY), 32'd16);
    send_item(CMD_GET, '0, VAL_ONES);          // lookup in an empty cache
    send_item(CMD_SET, '0, '0);
    send_item(CMD_SET, KEY_ONES, VAL_ONES);
    send_item(CMD_GET, '0, '0);
    send_item(CMD_GET, KEY_ONES, '0);
    send_item(CMD_SET, '0, 32'h1234_5678);     // overwrite of a present key
    send_item(CMD_GET, '0, '0);
    send_item(CMD_GET, k_a, '0);               // miss leaves state alone
    drain();
    // shrink to the two entries in use: every new key now evicts
    wr_reg(int'(REG_CAPACITY), 32'd2);
    wr_reg(int'(REG_CAPACITY) + 1, 32'd7);     // no register there, write dropped
    send_item(CMD_SET, k_a, 32'hA5A5_5A5A);    // evicts the all-ones key
    send_item(CMD_GET, KEY_ONES, '0);
    send_item(CMD_GET, k_a, '0);
    send_item(CMD_SET, '0, 32'h0BAD_F00D);     // set hit refreshes recency
    send_item(CMD_SET, k_b, 32'h8000_0001);    // so k_a goes, not key 0
    send_item(CMD_GET, k_a, '0);
    send_item(CMD_GET, '0, '0);
    send_item(CMD_GET, k_b, '0);
    send_item(CMD_SET, k_c, 32'h7FFF_FFFE);
    send_item(CMD_GET, k_c, '0);

    // --- random phases ---
    for (int p = 0; p < PHASES; p++) begin
      drain();
      wr_reg(int'(REG_CAPACITY), APB_DW'(phase_caps[p]));
      if (p < 3) begin
        src_idle_pct   = 13;
        sink_stall_pct = 59;
      end else if (p < 5) begin
        src_idle_pct   = 59;
        sink_stall_pct = 13;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      pool_len = shadow.eff_capacity() + 3;
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = {$urandom(), $urandom()};
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(negedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("[lru_key_value_cache_unit] OK");
    else
      $display("[lru_key_value_cache_unit] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
